/* rtl/ssut_pkg.sv */
// Shared types, command and status codes for the sorted unique set table.
package ssut_pkg;

    localparam int SSUT_CAPACITY = 32;
    localparam int ENTRY_W       = 32;
    localparam int COUNT_W       = 6;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_DUMP   = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_ABSENT   = 3'd3;
    localparam logic [2:0] ST_FOUND    = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_DUMP     = 3'd6;
    localparam logic [2:0] ST_EMPTY    = 3'd7;

    typedef logic signed [ENTRY_W-1:0] t_entry;

    typedef struct packed {
        logic [1:0] mode;
        t_entry     key_value;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         status;
        t_entry             entry_value;
        logic [COUNT_W-1:0] entry_count;
        logic               last;
    } t_result;

endpackage

/* rtl/ssut_mem.sv */
// Entry memory: one write port, one read port with registered read data.
module ssut_mem
    import ssut_pkg::*;
#(
    parameter int CAPACITY = SSUT_CAPACITY
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] i_waddr,
    input  t_entry                                 i_wdata,
    input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] i_raddr,
    output t_entry                                 o_rdata
);

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ssut_ctrl.sv */
// Command sequencer: ordered scan, shift up or down through memory, and dump.
module ssut_ctrl
    import ssut_pkg::*;
#(
    parameter int CAPACITY = SSUT_CAPACITY,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_cmd          i_cmd,
    output logic          o_busy,
    output logic          o_strobe,
    output t_result       o_result,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output t_entry        o_wdata,
    output logic [AW-1:0] o_raddr,
    input  t_entry        i_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_INS,
        S_DEL,
        S_DUMP
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_occ, n_occ;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pi, n_pi;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_pv, n_pv;
    logic          r_hit, n_hit;
    logic [1:0]    r_mode, n_mode;
    t_entry        r_key, n_key;
    logic          r_strb, n_strb;
    t_result       r_res, n_res;

    logic [CW-1:0] pi_inc, pi_dec, idx_inc, idx_dec, occ_inc, occ_dec;
    logic          less;

    assign pi_inc  = r_pi + 1'b1;
    assign pi_dec  = r_pi - 1'b1;
    assign idx_inc = r_idx + 1'b1;
    assign idx_dec = r_idx - 1'b1;
    assign occ_inc = r_occ + 1'b1;
    assign occ_dec = r_occ - 1'b1;
    assign less    = (i_rdata < r_key);

    always_comb begin
        n_state = r_state;
        n_occ   = r_occ;
        n_idx   = r_idx;
        n_pi    = r_pi;
        n_pos   = r_pos;
        n_pv    = r_pv;
        n_hit   = r_hit;
        n_mode  = r_mode;
        n_key   = r_key;
        n_strb  = 1'b0;
        n_res   = r_res;
        o_we    = 1'b0;
        o_waddr = pi_inc[AW-1:0];
        o_wdata = i_rdata;
        o_raddr = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_mode = i_cmd.mode;
                    n_key  = i_cmd.key_value;
                    n_idx  = '0;
                    n_pv   = 1'b0;
                    if (i_cmd.mode == MODE_DUMP) begin
                        if (r_occ == '0) begin
                            n_strb = 1'b1;
                            n_res  = '{status: ST_EMPTY, entry_value: '0,
                                       entry_count: COUNT_W'(r_occ), last: 1'b1};
                        end else begin
                            n_state = S_DUMP;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (r_idx < r_occ) begin
                    n_pv  = 1'b1;
                    n_idx = idx_inc;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv && !less) begin
                    n_pos   = idx_dec;
                    n_hit   = (i_rdata == r_key);
                    n_pv    = 1'b0;
                    n_state = S_DECIDE;
                end else if (r_idx >= r_occ) begin
                    n_pos   = r_occ;
                    n_hit   = 1'b0;
                    n_pv    = 1'b0;
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_pv  = 1'b0;
                n_res = '{status: ST_ABSENT, entry_value: r_key,
                          entry_count: COUNT_W'(r_occ), last: 1'b1};
                case (r_mode)
                    MODE_INSERT: begin
                        if (r_hit) begin
                            n_strb         = 1'b1;
                            n_res.status   = ST_DUP;
                            n_state        = S_IDLE;
                        end else if (r_occ >= CW'(CAPACITY)) begin
                            n_strb         = 1'b1;
                            n_res.status   = ST_FULL;
                            n_state        = S_IDLE;
                        end else begin
                            n_idx   = r_occ;
                            n_state = S_INS;
                        end
                    end
                    MODE_DELETE: begin
                        if (r_hit) begin
                            n_idx   = r_pos + 1'b1;
                            n_state = S_DEL;
                        end else begin
                            n_strb  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_strb       = 1'b1;
                        n_res.status = r_hit ? ST_FOUND : ST_ABSENT;
                        n_state      = S_IDLE;
                    end
                endcase
            end

            S_INS: begin
                if (r_pv) begin
                    o_we    = 1'b1;
                    o_waddr = pi_inc[AW-1:0];
                    o_wdata = i_rdata;
                end
                if (r_idx > r_pos) begin
                    o_raddr = idx_dec[AW-1:0];
                    n_pv    = 1'b1;
                    n_pi    = idx_dec;
                    n_idx   = idx_dec;
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        o_we    = 1'b1;
                        o_waddr = r_pos[AW-1:0];
                        o_wdata = r_key;
                        n_occ   = occ_inc;
                        n_strb  = 1'b1;
                        n_res   = '{status: ST_INSERTED, entry_value: r_key,
                                    entry_count: COUNT_W'(occ_inc), last: 1'b1};
                        n_state = S_IDLE;
                    end
                end
            end

            S_DEL: begin
                if (r_pv) begin
                    o_we    = 1'b1;
                    o_waddr = pi_dec[AW-1:0];
                    o_wdata = i_rdata;
                end
                if (r_idx < r_occ) begin
                    n_pv  = 1'b1;
                    n_pi  = r_idx;
                    n_idx = idx_inc;
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_occ   = occ_dec;
                        n_strb  = 1'b1;
                        n_res   = '{status: ST_REMOVED, entry_value: r_key,
                                    entry_count: COUNT_W'(occ_dec), last: 1'b1};
                        n_state = S_IDLE;
                    end
                end
            end

            S_DUMP: begin
                if (r_idx < r_occ) begin
                    n_pv  = 1'b1;
                    n_pi  = r_idx;
                    n_idx = idx_inc;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    n_strb = 1'b1;
                    n_res  = '{status: ST_DUMP, entry_value: i_rdata,
                               entry_count: COUNT_W'(r_occ), last: (pi_inc == r_occ)};
                    if (pi_inc == r_occ) begin
                        n_pv    = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
                n_pv    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_pv    <= 1'b0;
            r_strb  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_pv    <= n_pv;
            r_strb  <= n_strb;
        end
        r_idx  <= n_idx;
        r_pi   <= n_pi;
        r_pos  <= n_pos;
        r_hit  <= n_hit;
        r_mode <= n_mode;
        r_key  <= n_key;
        r_res  <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strb;
    assign o_result = r_res;

endmodule

/* rtl/sorted_unique_set_table.sv */
// Top level of the sorted unique set table: sequencer plus entry memory.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------
//  command   | start, busy           | i_cmd    (mode, key_value)
//  result    | o_strobe (no stall)   | o_result (status, entry_value,
//            |                       |           entry_count, last)
//
//  One command at a time; busy stays high until its last result is issued.
//  The registered memory read sets the pace; with n entries held and the
//  key found at slot p, search and failed insert/delete scale with p,
//  insert, delete and dump with n, and an empty dump gives one result without leaving idle.
//  Reset clears the state, the entry count and the valid and strobe flags; memory contents need no clearing.
//  Results appear for one cycle each; a dump streams one entry per cycle.
module sorted_unique_set_table
    import ssut_pkg::*;
#(
    parameter int CAPACITY = SSUT_CAPACITY
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_wdata;
    t_entry        mem_rdata;

    ssut_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .o_busy  (busy),
        .o_strobe(o_strobe),
        .o_result(o_result),
        .o_we    (mem_we),
        .o_waddr (mem_waddr),
        .o_wdata (mem_wdata),
        .o_raddr (mem_raddr),
        .i_rdata (mem_rdata)
    );

    ssut_mem #(
        .CAPACITY(CAPACITY)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

endmodule

/* sim/ssut_checker.sv */
// Checker for the sorted unique set table: tracks the set, predicts results, compares them.
module ssut_checker
    import ssut_pkg::*;
#(
    parameter int CAPACITY = SSUT_CAPACITY
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_cmd    i_cmd,
    input  logic    i_strobe,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending
);

    t_entry  set_entries[$];
    t_result expected_results[$];
    int      fail_count = 0;

    function automatic t_result make_result(logic [2:0] status, t_entry value, logic last);
        t_result r;
        r.status      = status;
        r.entry_value = value;
        r.entry_count = COUNT_W'(set_entries.size());
        r.last        = last;
        return r;
    endfunction

    task automatic apply_set_cmd(input t_cmd cmd);
        int     slot;
        logic   hit;
        t_entry key;
        key  = cmd.key_value;
        slot = 0;
        while (slot < set_entries.size() && set_entries[slot] < key) slot++;
        hit = (slot < set_entries.size()) && (set_entries[slot] == key);
        case (cmd.mode)
            MODE_INSERT: begin
                if (hit) begin
                    expected_results.push_back(make_result(ST_DUP, key, 1'b1));
                end else if (set_entries.size() >= CAPACITY) begin
                    expected_results.push_back(make_result(ST_FULL, key, 1'b1));
                end else begin
                    set_entries.insert(slot, key);
                    expected_results.push_back(make_result(ST_INSERTED, key, 1'b1));
                end
            end
            MODE_DELETE: begin
                if (hit) begin
                    set_entries.delete(slot);
                    expected_results.push_back(make_result(ST_REMOVED, key, 1'b1));
                end else begin
                    expected_results.push_back(make_result(ST_ABSENT, key, 1'b1));
                end
            end
            MODE_SEARCH: begin
                expected_results.push_back(make_result(hit ? ST_FOUND : ST_ABSENT, key, 1'b1));
            end
            default: begin
                if (set_entries.size() == 0) begin
                    expected_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
                end else begin
                    foreach (set_entries[i])
                        expected_results.push_back(make_result(ST_DUMP, set_entries[i],
                            logic'(i == set_entries.size() - 1)));
                end
            end
        endcase
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result status=%0d value=%0d count=%0d last=%0b",
                     $time, got.status, got.entry_value, got.entry_count, got.last);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status || got.entry_value !== want.entry_value ||
                got.entry_count !== want.entry_count || got.last !== want.last) begin
                $display("%0t: mismatch expected status=%0d value=%0d count=%0d last=%0b",
                         $time, want.status, want.entry_value, want.entry_count, want.last);
                $display("%0t:          actual status=%0d value=%0d count=%0d last=%0b",
                         $time, got.status, got.entry_value, got.entry_count, got.last);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_entries.delete();
            expected_results.delete();
        end else begin
            if (i_start && !i_busy) apply_set_cmd(i_cmd);
            if (i_strobe) check_result(i_result);
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

/* sim/tb.sv */
// Testbench top: drives set commands into the sorted unique set table and gives the verdict.
module tb;
    import ssut_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int ROUNDS         = 7;
    localparam int ROUND_ITEMS    = 40;
    localparam int POOL_GROWTH    = 24;

    logic    i_clk     = 1'b0;
    logic    i_rst_n   = 1'b0;
    logic    start     = 1'b0;
    t_cmd    i_cmd     = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    logic    cmd_taken   = 1'b0;
    logic    idling_on   = 1'b1;
    int      idle_cycles = 0;
    int      fail_count;
    int      pending;
    t_entry  key_pool[$];

    sorted_unique_set_table DUT (
        .i_clk,
        .i_rst_n,
        .start,
        .i_cmd,
        .busy,
        .o_strobe,
        .o_result
    );

    ssut_checker u_checker (
        .i_clk,
        .i_rst_n,
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd,
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cmd_taken <= i_rst_n && start && !busy;
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    // call at a falling edge; returns at the falling edge after the item is taken
    task automatic send_cmd(input logic [1:0] mode, input t_entry key);
        start <= 1'b1;
        i_cmd <= '{mode: mode, key_value: key};
        do @(negedge i_clk); while (!cmd_taken);
    endtask

    task automatic idle_gap();
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic grow_pool(input int count);
        t_entry base;
        int     k;
        base = t_entry'($urandom);
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 3))
                0: key_pool.push_back(t_entry'($urandom));
                1: key_pool.push_back(base + t_entry'($urandom_range(0, 63)));
                2: key_pool.push_back($urandom_range(0, 1) ?
                       t_entry'(32'h8000_0000 + $urandom_range(0, 7)) :
                       t_entry'(32'h7FFF_FFFF - $urandom_range(0, 7)));
                default: key_pool.push_back(t_entry'($urandom_range(0, 40)) - 20);
            endcase
        end
    endtask

    function automatic t_entry pick_key();
        if ($urandom_range(0, 9) == 0) return t_entry'($urandom);
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    function automatic logic [1:0] pick_mode(input logic filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return MODE_DUMP;
        if (roll < 20) return MODE_SEARCH;
        if (roll < (filling ? 85 : 40)) return MODE_INSERT;
        return MODE_DELETE;
    endfunction

    task automatic send_directed(input logic [1:0] mode, input t_entry key);
        send_cmd(mode, key);
        idle_gap();
    endtask

    initial begin
        int   r;
        int   n;
        logic filling;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_directed(MODE_DUMP,   t_entry'($urandom));
        send_directed(MODE_SEARCH, 0);
        send_directed(MODE_DELETE, 0);
        send_directed(MODE_INSERT, t_entry'(32'h7FFF_FFFF));
        send_directed(MODE_INSERT, t_entry'(32'h8000_0000));
        send_directed(MODE_INSERT, 0);
        send_directed(MODE_INSERT, -1);
        send_directed(MODE_INSERT, 1);
        send_directed(MODE_INSERT, t_entry'(32'h7FFF_FFFF));
        send_directed(MODE_SEARCH, t_entry'(32'h8000_0000));
        send_directed(MODE_SEARCH, t_entry'(32'h7FFF_FFFE));
        send_directed(MODE_DELETE, -1);
        send_directed(MODE_DELETE, -1);
        send_directed(MODE_DUMP,   t_entry'($urandom));
        send_directed(MODE_INSERT, t_entry'(32'h5555_5555));
        send_directed(MODE_INSERT, t_entry'(32'hAAAA_AAAA));
        send_directed(MODE_DELETE, t_entry'(32'h8000_0000));
        send_directed(MODE_DELETE, t_entry'(32'h7FFF_FFFF));
        send_directed(MODE_SEARCH, 1);
        send_directed(MODE_DUMP,   t_entry'($urandom));
        drain_results();

        for (r = 0; r < ROUNDS; r++) begin
            filling = (r % 3 != 2);
            if (filling) grow_pool(POOL_GROWTH);
            if (r == ROUNDS - 1) idling_on = 1'b0;
            for (n = 0; n < ROUND_ITEMS; n++) begin
                send_cmd(pick_mode(filling), pick_key());
                idle_gap();
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ssut_pkg.sv
rtl/ssut_mem.sv
rtl/ssut_ctrl.sv
rtl/sorted_unique_set_table.sv
sim/ssut_checker.sv
sim/tb.sv
